>>> rtl/mclp_pkg.sv
// Package for the MIDI clock master looper: shared types, codes and constants.
// Used by every file of the block but mclp_if.sv; depends on nothing.
package mclp_pkg;

    localparam int MEASURE_TICKS_DEF = 96;
    localparam int QUEUE_DEPTH       = 2;

    localparam int POS_W    = 32;
    localparam int TIME_W   = 16;
    localparam int LOOP_W   = 17;
    localparam int SPP_W    = 14;
    localparam int CFG_W    = 17;

    localparam logic [TIME_W-1:0] PERIOD_RESET = 16'd5000;

    // Divide by six as a multiply by reciprocal, exact for 17-bit inputs
    localparam logic [15:0] SPP_RECIP = 16'd43691;
    localparam int          SPP_SHIFT = 18;

    typedef enum logic [1:0] {
        ACT_TIME  = 2'd0,
        ACT_CLOCK = 2'd1,
        ACT_START = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        MSG_CLOCK    = 2'd0,
        MSG_STOP     = 2'd1,
        MSG_SONGPOS  = 2'd2,
        MSG_CONTINUE = 2'd3
    } t_msg;

    typedef enum logic [1:0] {
        CFG_MASTER     = 2'd0,
        CFG_PERIOD     = 2'd1,
        CFG_LOOP_START = 2'd2,
        CFG_LOOP_END   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                 we;
        t_cfg_idx             idx;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

    typedef struct packed {
        logic                 jump;
        logic [SPP_W-1:0]     spp;
    } t_cmd;

    typedef struct packed {
        logic                 push;
        t_cmd                 cmd;
    } t_q_wr;

    typedef struct packed {
        logic                 valid;
        t_cmd                 cmd;
    } t_q_rd;

endpackage

>>> rtl/mclp_if.sv
// Handshake interfaces for the looper's input and message channels.
// Depends on nothing.
interface mclp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] now_time;

    modport source (output valid, output action, output now_time, input ready);
    modport sink   (input valid, input action, input now_time, output ready);
endinterface

interface mclp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  msg_kind;
    logic [13:0] song_position;
    logic        last;

    modport source (output valid, output msg_kind, output song_position, output last,
                    input ready);
    modport sink   (input valid, input msg_kind, input song_position, input last,
                    output ready);
endinterface

>>> rtl/mclp_front.sv
// Front end: configuration registers, position and clock timing state, loop decision.
// Depends on mclp_pkg and mclp_in_if; feeds the command queue.
module mclp_front
    import mclp_pkg::*;
#(
    parameter int MEASURE_TICKS = MEASURE_TICKS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg_wr       i_cfg,
    mclp_in_if.sink       i_item,
    input  logic          i_q_full,
    output t_q_wr         o_q
);

    localparam int PHASE_W  = (MEASURE_TICKS > 1) ? $clog2(MEASURE_TICKS) : 1;
    localparam int RECIP_K  = 28;
    localparam int RECIP_W  = RECIP_K + 1;
    localparam int PROD_W   = RECIP_W + LOOP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_K) + 64'(MEASURE_TICKS) - 64'd1) / 64'(MEASURE_TICKS));
    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(MEASURE_TICKS - 1);
    localparam logic [LOOP_W-1:0]  TICKS_L    = LOOP_W'(MEASURE_TICKS);
    localparam int SPP_PROD_W = LOOP_W + 16;

    logic                 r_master;
    logic [TIME_W-1:0]    r_period;
    logic [LOOP_W-1:0]    r_loop_start;
    logic [LOOP_W-1:0]    r_loop_end;
    logic [POS_W-1:0]     r_position;
    logic [PHASE_W-1:0]   r_phase;
    logic [TIME_W-1:0]    r_last_time;
    logic [1:0]           r_busy;
    logic [LOOP_W-1:0]    r_ls_q;
    logic [SPP_W-1:0]     r_ls_spp;
    logic [PHASE_W-1:0]   r_ls_phase;

    logic                 accept;
    logic                 tick;
    logic                 jump;
    logic                 boundary;
    logic                 window_out;
    logic [TIME_W-1:0]    elapsed;
    logic [POS_W:0]       pos_inc;
    logic [POS_W-1:0]     p1;
    logic [PHASE_W-1:0]   phase_inc;
    logic [PROD_W-1:0]    ls_prod;
    logic [SPP_PROD_W-1:0] spp_prod;
    logic [SPP_PROD_W-SPP_SHIFT-1:0] spp_q;
    logic [LOOP_W-1:0]    ls_rem;

    assign accept    = i_item.valid && i_item.ready;
    assign elapsed   = i_item.now_time - r_last_time;
    assign tick      = (i_item.action == ACT_TIME) && r_master && (elapsed >= r_period);
    assign pos_inc   = {1'b0, r_position} + {{POS_W{1'b0}}, 1'b1};
    assign p1        = pos_inc[POS_W-1:0];
    assign phase_inc = (pos_inc[POS_W] || r_phase == LAST_PHASE) ? '0 : r_phase + 1'b1;
    assign boundary  = (phase_inc == '0);
    assign window_out = (r_loop_end != '0)
                     && ((p1 >= POS_W'(r_loop_end)) || (p1 < POS_W'(r_loop_start)));
    assign jump      = boundary && window_out;

    assign ls_prod   = PROD_W'(r_loop_start) * PROD_W'(RECIP);
    assign spp_prod  = SPP_PROD_W'(r_loop_start) * SPP_PROD_W'(SPP_RECIP);
    assign spp_q     = spp_prod[SPP_PROD_W-1:SPP_SHIFT];
    assign ls_rem    = r_loop_start - LOOP_W'(r_ls_q * TICKS_L);

    assign i_item.ready = !i_q_full && (r_busy == 2'd0);

    assign o_q.push     = accept && tick;
    assign o_q.cmd.jump = jump;
    assign o_q.cmd.spp  = r_ls_spp;

    always_ff @(posedge i_clk) begin
        r_ls_q     <= ls_prod[RECIP_K+LOOP_W-1:RECIP_K];
        r_ls_spp   <= (spp_q > (SPP_PROD_W-SPP_SHIFT)'({SPP_W{1'b1}}))
                      ? {SPP_W{1'b1}} : spp_q[SPP_W-1:0];
        r_ls_phase <= ls_rem[PHASE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master     <= 1'b0;
            r_period     <= PERIOD_RESET;
            r_loop_start <= '0;
            r_loop_end   <= '0;
            r_position   <= '0;
            r_phase      <= '0;
            r_last_time  <= '0;
            r_busy       <= 2'd2;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    CFG_MASTER:     r_master     <= i_cfg.data[0];
                    CFG_PERIOD:     r_period     <= i_cfg.data[TIME_W-1:0];
                    CFG_LOOP_START: r_loop_start <= i_cfg.data[LOOP_W-1:0];
                    CFG_LOOP_END:   r_loop_end   <= i_cfg.data[LOOP_W-1:0];
                    default: ;
                endcase
            end
            if (i_cfg.we && i_cfg.idx == CFG_LOOP_START) begin
                r_busy <= 2'd2;
            end else if (r_busy != 2'd0) begin
                r_busy <= r_busy - 2'd1;
            end
            if (accept) begin
                case (i_item.action)
                    ACT_CLOCK: begin
                        if (!r_master) begin
                            r_position <= p1;
                            r_phase    <= phase_inc;
                        end
                    end
                    ACT_START: begin
                        r_position <= '0;
                        r_phase    <= '0;
                    end
                    ACT_TIME: begin
                        if (tick) begin
                            r_last_time <= i_item.now_time;
                            if (jump) begin
                                r_position <= POS_W'(r_loop_start);
                                r_phase    <= r_ls_phase;
                            end else begin
                                r_position <= p1;
                                r_phase    <= phase_inc;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> rtl/mclp_queue.sv
// Short command queue between the looper's front and back ends.
// Depends on mclp_pkg.
module mclp_queue
    import mclp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_q_wr  i_wr,
    input  logic   i_pop,
    output t_q_rd  o_rd,
    output logic   o_full
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_cmd           r_mem [QUEUE_DEPTH];
    logic [AW-1:0]  r_wptr;
    logic [AW-1:0]  r_rptr;
    logic [AW:0]    r_count;
    logic           do_pop;

    assign o_full     = (r_count == (AW+1)'(QUEUE_DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.cmd   = r_mem[r_rptr];
    assign do_pop     = i_pop && o_rd.valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wptr] <= i_wr.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr.push) begin
                r_wptr <= (r_wptr == AW'(QUEUE_DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(QUEUE_DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_wr.push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/mclp_back.sv
// Back end: turns queued commands into MIDI messages through an output register.
// Depends on mclp_pkg and mclp_out_if.
module mclp_back
    import mclp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_rd       i_q,
    output logic        o_pop,
    mclp_out_if.source  o_msg
);

    typedef enum logic [1:0] {
        ST_NEW,
        ST_SPP,
        ST_CONT,
        ST_CLK
    } t_state;

    t_state            r_state;
    logic              r_valid;
    t_msg              r_kind;
    logic [SPP_W-1:0]  r_spp;
    logic              r_last;
    logic              load;
    logic              emit_clock;

    assign load       = i_q.valid && (!r_valid || o_msg.ready);
    assign emit_clock = (r_state == ST_CLK) || (r_state == ST_NEW && !i_q.cmd.jump);
    assign o_pop      = load && emit_clock;

    assign o_msg.valid         = r_valid;
    assign o_msg.msg_kind      = r_kind;
    assign o_msg.song_position = r_spp;
    assign o_msg.last          = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_NEW;
            r_valid <= 1'b0;
            r_kind  <= MSG_CLOCK;
            r_spp   <= '0;
            r_last  <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_spp   <= '0;
                r_last  <= 1'b0;
                case (r_state)
                    ST_NEW: begin
                        if (i_q.cmd.jump) begin
                            r_kind  <= MSG_STOP;
                            r_state <= ST_SPP;
                        end else begin
                            r_kind  <= MSG_CLOCK;
                            r_last  <= 1'b1;
                        end
                    end
                    ST_SPP: begin
                        r_kind  <= MSG_SONGPOS;
                        r_spp   <= i_q.cmd.spp;
                        r_state <= ST_CONT;
                    end
                    ST_CONT: begin
                        r_kind  <= MSG_CONTINUE;
                        r_state <= ST_CLK;
                    end
                    ST_CLK: begin
                        r_kind  <= MSG_CLOCK;
                        r_last  <= 1'b1;
                        r_state <= ST_NEW;
                    end
                    default: r_state <= ST_NEW;
                endcase
            end else if (o_msg.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/midi_clock_master_looper_core.sv
// Top level of the MIDI clock master looper: front end, command queue, back end.
// Depends on mclp_pkg, mclp_in_if, mclp_out_if, mclp_front, mclp_queue, mclp_back.
//
// The block takes one input transaction per cycle unless the queue is full or it is held off;
// a clock tick yields one message, a tick that restarts the loop yields four (stop, song
// position, continue, clock), sent by the output sequencer at one message per cycle while the
// output is ready, from a two-entry queue. After reset and after every loop_start write the
// input is held off while the loop start is reduced to its measure phase and song position.
module midi_clock_master_looper_core
    import mclp_pkg::*;
#(
    parameter int MEASURE_TICKS = MEASURE_TICKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    mclp_in_if.sink           i_item,
    mclp_out_if.source        o_msg
);

    t_cfg_wr  cfg;
    t_q_wr    q_wr;
    t_q_rd    q_rd;
    logic     q_full;
    logic     q_pop;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = t_cfg_idx'(i_cfg_idx);
    assign cfg.data = i_cfg_data;

    mclp_front #(
        .MEASURE_TICKS (MEASURE_TICKS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q      (q_wr)
    );

    mclp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_rd    (q_rd),
        .o_full  (q_full)
    );

    mclp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q_rd),
        .o_pop   (q_pop),
        .o_msg   (o_msg)
    );

    a_last_on_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_msg.valid |-> ((o_msg.msg_kind == MSG_CLOCK) == o_msg.last))
        else $error("last flag does not match clock message");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr.push |-> !q_full)
        else $error("command queue overflow");

    a_stop_then_spp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_msg.valid && o_msg.ready && o_msg.msg_kind == MSG_STOP)
        |=> (o_msg.valid && o_msg.msg_kind == MSG_SONGPOS))
        else $error("stop not followed by song position");

endmodule
